/* rtl/etok_pkg.sv */
// Shared types, codes and character classes for the expression tokenizer.
// No dependencies; etok_lex, etok_outq and the top take their names from here.

package etok_pkg;

	localparam int POS_BITS = 16;
	localparam int EXT_BITS = (POS_BITS > 16) ? POS_BITS : 16;
	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

	// lexer modes
	localparam logic [3:0] M_IDLE    = 4'd0;
	localparam logic [3:0] M_INT     = 4'd1;
	localparam logic [3:0] M_FRAC    = 4'd2;
	localparam logic [3:0] M_EXPMARK = 4'd3;
	localparam logic [3:0] M_EXPSIGN = 4'd4;
	localparam logic [3:0] M_EXPDIG  = 4'd5;
	localparam logic [3:0] M_IDENT   = 4'd6;
	localparam logic [3:0] M_DOT     = 4'd7;
	localparam logic [3:0] M_ERR     = 4'd8;

	// token kinds
	localparam logic [3:0] K_NUM    = 4'd0;
	localparam logic [3:0] K_IDENT  = 4'd1;
	localparam logic [3:0] K_PLUS   = 4'd2;
	localparam logic [3:0] K_MINUS  = 4'd3;
	localparam logic [3:0] K_STAR   = 4'd4;
	localparam logic [3:0] K_SLASH  = 4'd5;
	localparam logic [3:0] K_CARET  = 4'd6;
	localparam logic [3:0] K_LPAREN = 4'd7;
	localparam logic [3:0] K_RPAREN = 4'd8;
	localparam logic [3:0] K_EQUAL  = 4'd9;
	localparam logic [3:0] K_END    = 4'd10;
	localparam logic [3:0] K_BADEXP = 4'd11;
	localparam logic [3:0] K_UNEXP  = 4'd12;

	localparam logic ACT_CHAR = 1'b0;
	localparam logic ACT_END  = 1'b1;

	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_E_LO   = 8'h65;
	localparam logic [7:0] CH_E_UP   = 8'h45;

	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] start_pos;
		logic [15:0] length;
		logic        final_res;
		logic        run_last;
	} etok_res_t;

	// results of one accepted request: count is 0, 1 or 2
	typedef struct packed {
		logic [1:0] count;
		etok_res_t  r0;
		etok_res_t  r1;
	} etok_wr_t;

	typedef struct packed {
		logic [3:0]          mode;
		logic [POS_BITS-1:0] position;
	} etok_stat_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	function automatic logic [3:0] op_kind(input logic [7:0] c);
		logic [3:0] k;
		case (c)
			CH_PLUS:   k = K_PLUS;
			CH_MINUS:  k = K_MINUS;
			CH_STAR:   k = K_STAR;
			CH_SLASH:  k = K_SLASH;
			CH_CARET:  k = K_CARET;
			CH_LPAREN: k = K_LPAREN;
			CH_RPAREN: k = K_RPAREN;
			CH_EQUAL:  k = K_EQUAL;
			default:   k = K_NUM;
		endcase
		return k;
	endfunction

	function automatic logic [15:0] sat16(input logic [POS_BITS-1:0] v);
		logic [EXT_BITS-1:0] e;
		e = EXT_BITS'(v);
		if (e > EXT_BITS'(17'h0FFFF)) begin
			return 16'hFFFF;
		end
		return e[15:0];
	endfunction

	function automatic etok_res_t mk_res(input logic [3:0] kind,
			input logic [POS_BITS-1:0] start, input logic [POS_BITS-1:0] len,
			input logic fin);
		etok_res_t r;
		r.kind      = kind;
		r.start_pos = sat16(start);
		r.length    = sat16(len);
		r.final_res = fin;
		r.run_last  = 1'b0;
		return r;
	endfunction

endpackage

/* rtl/etok_in_if.sv */
// Request channel of the expression tokenizer: one character or end mark.
// Depends on nothing.

interface etok_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] ch;

	modport source (output valid, output action, output ch, input ready);
	modport sink (input valid, input action, input ch, output ready);
endinterface

/* rtl/etok_out_if.sv */
// Result channel of the expression tokenizer: one token or error per transfer.
// Depends on nothing.

interface etok_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  kind;
	logic [15:0] start_pos;
	logic [15:0] length;
	logic        final_res;
	logic        run_last;

	modport source (output valid, output kind, output start_pos, output length,
		output final_res, output run_last, input ready);
	modport sink (input valid, input kind, input start_pos, input length,
		input final_res, input run_last, output ready);
endinterface

/* rtl/etok_lex.sv */
// Lexer state registers and the per-character next-state / token logic.
// Depends on etok_pkg.

module etok_lex (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic                 action,
	input  logic [7:0]           ch,
	output etok_pkg::etok_wr_t   wr,
	output etok_pkg::etok_stat_t stat
);

	logic [3:0]                    mode_q;
	logic [etok_pkg::POS_BITS-1:0] pos_q;
	logic [etok_pkg::POS_BITS-1:0] tstart_q;

	logic [3:0]                    mode_n;
	logic [etok_pkg::POS_BITS-1:0] pos_n;
	logic [etok_pkg::POS_BITS-1:0] tstart_n;
	logic [etok_pkg::POS_BITS-1:0] open_len;
	logic [etok_pkg::POS_BITS-1:0] one;
	logic                          done;
	logic [1:0]                    n;
	etok_pkg::etok_res_t           r0;
	etok_pkg::etok_res_t           r1;
	etok_pkg::etok_res_t           rc;

	assign open_len = (pos_q >= tstart_q) ? (pos_q - tstart_q) : '0;
	assign one = etok_pkg::POS_BITS'(1);

	always_comb begin
		mode_n   = mode_q;
		tstart_n = tstart_q;
		pos_n    = (pos_q != etok_pkg::POS_MAX) ? (pos_q + one) : pos_q;
		done     = 1'b0;
		n        = 2'd0;
		r0       = etok_pkg::mk_res(etok_pkg::K_END, pos_q, '0, 1'b1);
		r1       = r0;
		rc       = r0;
		if (action == etok_pkg::ACT_END) begin
			mode_n   = etok_pkg::M_IDLE;
			pos_n    = '0;
			tstart_n = '0;
			case (mode_q)
				etok_pkg::M_INT, etok_pkg::M_FRAC, etok_pkg::M_EXPDIG: begin
					r0 = etok_pkg::mk_res(etok_pkg::K_NUM, tstart_q, open_len, 1'b0);
					r1 = etok_pkg::mk_res(etok_pkg::K_END, pos_q, '0, 1'b1);
					n  = 2'd2;
				end
				etok_pkg::M_IDENT: begin
					r0 = etok_pkg::mk_res(etok_pkg::K_IDENT, tstart_q, open_len, 1'b0);
					r1 = etok_pkg::mk_res(etok_pkg::K_END, pos_q, '0, 1'b1);
					n  = 2'd2;
				end
				etok_pkg::M_EXPMARK, etok_pkg::M_EXPSIGN: begin
					r0 = etok_pkg::mk_res(etok_pkg::K_BADEXP, tstart_q, '0, 1'b1);
					n  = 2'd1;
				end
				etok_pkg::M_DOT: begin
					r0 = etok_pkg::mk_res(etok_pkg::K_UNEXP, tstart_q, '0, 1'b1);
					n  = 2'd1;
				end
				etok_pkg::M_ERR: begin
					n = 2'd0;
				end
				default: begin
					n = 2'd1;
				end
			endcase
		end else begin
			case (mode_q)
				etok_pkg::M_INT: begin
					if (etok_pkg::is_digit(ch)) begin
						done = 1'b1;
					end else if (ch == etok_pkg::CH_DOT) begin
						mode_n = etok_pkg::M_FRAC;
						done   = 1'b1;
					end else if (ch == etok_pkg::CH_E_LO || ch == etok_pkg::CH_E_UP) begin
						mode_n = etok_pkg::M_EXPMARK;
						done   = 1'b1;
					end
				end
				etok_pkg::M_FRAC: begin
					if (etok_pkg::is_digit(ch)) begin
						done = 1'b1;
					end else if (ch == etok_pkg::CH_E_LO || ch == etok_pkg::CH_E_UP) begin
						mode_n = etok_pkg::M_EXPMARK;
						done   = 1'b1;
					end
				end
				etok_pkg::M_EXPMARK: begin
					done = 1'b1;
					if (ch == etok_pkg::CH_PLUS || ch == etok_pkg::CH_MINUS) begin
						mode_n = etok_pkg::M_EXPSIGN;
					end else if (etok_pkg::is_digit(ch)) begin
						mode_n = etok_pkg::M_EXPDIG;
					end else begin
						r0     = etok_pkg::mk_res(etok_pkg::K_BADEXP, tstart_q, '0, 1'b1);
						n      = 2'd1;
						mode_n = etok_pkg::M_ERR;
					end
				end
				etok_pkg::M_EXPSIGN: begin
					done = 1'b1;
					if (etok_pkg::is_digit(ch)) begin
						mode_n = etok_pkg::M_EXPDIG;
					end else begin
						r0     = etok_pkg::mk_res(etok_pkg::K_BADEXP, tstart_q, '0, 1'b1);
						n      = 2'd1;
						mode_n = etok_pkg::M_ERR;
					end
				end
				etok_pkg::M_EXPDIG: begin
					done = etok_pkg::is_digit(ch);
				end
				etok_pkg::M_IDENT: begin
					done = etok_pkg::is_alpha(ch) || etok_pkg::is_digit(ch) ||
						(ch == etok_pkg::CH_UNDER);
				end
				etok_pkg::M_DOT: begin
					done = 1'b1;
					if (etok_pkg::is_digit(ch)) begin
						mode_n = etok_pkg::M_FRAC;
					end else begin
						r0     = etok_pkg::mk_res(etok_pkg::K_UNEXP, tstart_q, '0, 1'b1);
						n      = 2'd1;
						mode_n = etok_pkg::M_ERR;
					end
				end
				etok_pkg::M_ERR: begin
					done = 1'b1;
				end
				default: begin
					done = 1'b0;
				end
			endcase

			if (!done) begin
				// close the open number or identifier, then look at ch as a new token
				if (mode_q == etok_pkg::M_INT || mode_q == etok_pkg::M_FRAC ||
						mode_q == etok_pkg::M_EXPDIG || mode_q == etok_pkg::M_IDENT) begin
					r0 = etok_pkg::mk_res((mode_q == etok_pkg::M_IDENT) ?
						etok_pkg::K_IDENT : etok_pkg::K_NUM, tstart_q, open_len, 1'b0);
					n  = 2'd1;
				end
				mode_n = etok_pkg::M_IDLE;
				if (etok_pkg::is_space(ch)) begin
					mode_n = etok_pkg::M_IDLE;
				end else if (etok_pkg::is_digit(ch)) begin
					tstart_n = pos_q;
					mode_n   = etok_pkg::M_INT;
				end else if (ch == etok_pkg::CH_DOT) begin
					tstart_n = pos_q;
					mode_n   = etok_pkg::M_DOT;
				end else if (etok_pkg::is_alpha(ch) || ch == etok_pkg::CH_UNDER) begin
					tstart_n = pos_q;
					mode_n   = etok_pkg::M_IDENT;
				end else begin
					if (etok_pkg::op_kind(ch) != etok_pkg::K_NUM) begin
						rc = etok_pkg::mk_res(etok_pkg::op_kind(ch), pos_q, one, 1'b0);
					end else begin
						rc     = etok_pkg::mk_res(etok_pkg::K_UNEXP, pos_q, '0, 1'b1);
						mode_n = etok_pkg::M_ERR;
					end
					if (n == 2'd0) begin
						r0 = rc;
					end else begin
						r1 = rc;
					end
					n = n + 2'd1;
				end
			end
		end

		if (n == 2'd1) begin
			r0.run_last = 1'b1;
		end
		if (n == 2'd2) begin
			r1.run_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= etok_pkg::M_IDLE;
			pos_q    <= '0;
			tstart_q <= '0;
		end else if (accept) begin
			mode_q   <= mode_n;
			pos_q    <= pos_n;
			tstart_q <= tstart_n;
		end
	end

	assign wr.count = accept ? n : 2'd0;
	assign wr.r0    = r0;
	assign wr.r1    = r1;

	assign stat.mode     = mode_q;
	assign stat.position = pos_q;

endmodule

/* rtl/etok_outq.sv */
// Four-entry result queue: takes up to two results per cycle, hands out one when ready is high.
// Depends on etok_pkg.

module etok_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  etok_pkg::etok_wr_t  wr,
	output logic                room,
	output logic                valid,
	input  logic                ready,
	output etok_pkg::etok_res_t res,
	output logic [2:0]          level
);

	etok_pkg::etok_res_t slot_q [4];
	logic [1:0]          wp_q;
	logic [1:0]          rp_q;
	logic [2:0]          cnt_q;
	logic                pop;

	assign valid = (cnt_q != 3'd0);
	assign pop   = valid && ready;
	assign room  = (cnt_q <= 3'd2);
	assign res   = slot_q[rp_q];
	assign level = cnt_q;

	always_ff @(posedge clk) begin
		if (wr.count != 2'd0) begin
			slot_q[wp_q] <= wr.r0;
		end
		if (wr.count == 2'd2) begin
			slot_q[wp_q + 2'd1] <= wr.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + wr.count;
			rp_q  <= rp_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, wr.count} - {2'b00, pop};
		end
	end

endmodule

/* rtl/expression_tokenizer_top.sv */
// Streaming expression lexer: one source character or end mark per request in,
// tokens out. Uses etok_pkg, etok_in_if, etok_out_if, etok_lex and etok_outq.

// A request (character or end mark) is taken one per clock whenever the four-entry
// result queue has room for two more results; the lexer state updates in that same
// cycle and its results (zero, one or two) enter the queue. Results leave the queue
// one per cycle while tok_out.ready is high, so a stream that produces two results
// per request runs at the output rate of one result per clock. A result waits in the
// queue until those ahead of it leave. No setup or clearing time is needed after reset.

module expression_tokenizer_top (
	input logic        clk,
	input logic        arst_n,
	etok_in_if.sink    tok_in,
	etok_out_if.source tok_out
);

	etok_pkg::etok_wr_t   wr;
	etok_pkg::etok_stat_t stat;
	etok_pkg::etok_res_t  res;
	logic                 room;
	logic                 accept;
	logic [2:0]           level;

	assign tok_in.ready = room;
	assign accept       = tok_in.valid && room;

	etok_lex u_lex (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.action (tok_in.action),
		.ch     (tok_in.ch),
		.wr     (wr),
		.stat   (stat)
	);

	etok_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.room   (room),
		.valid  (tok_out.valid),
		.ready  (tok_out.ready),
		.res    (res),
		.level  (level)
	);

	assign tok_out.kind      = res.kind;
	assign tok_out.start_pos = res.start_pos;
	assign tok_out.length    = res.length;
	assign tok_out.final_res = res.final_res;
	assign tok_out.run_last  = res.run_last;

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= 3'd4)
		else $error("result queue overflow");

	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && tok_in.action == etok_pkg::ACT_END |=>
		stat.mode == etok_pkg::M_IDLE && stat.position == '0)
		else $error("end request did not restart the lexer");

	a_final_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		tok_out.valid && tok_out.final_res |-> tok_out.run_last)
		else $error("closing result is not the last of its request");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		tok_out.valid |-> tok_out.kind <= etok_pkg::K_UNEXP)
		else $error("result kind out of range");

endmodule
